>>> sv/gtlb_pkg.sv
// Shared types, constants and break-class functions of the greedy line breaker.
package gtlb_pkg;

	localparam int LINE_GLYPHS_DEF = 32;
	localparam int CODE_W          = 21;
	localparam int MET_W           = 22;
	localparam int IDX_W           = 16;
	localparam int TOP_W           = 32;
	localparam int CFG_IDX_W       = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WRAP_WIDTH  = 2'd0,
		REG_FIRST_INSET = 2'd1,
		REG_LINE_INSET  = 2'd2,
		REG_LINE_GAP    = 2'd3
	} cfg_reg_t;

	// Character codes with a meaning of their own
	localparam logic [CODE_W-1:0] CH_NUL = 21'h00000;
	localparam logic [CODE_W-1:0] CH_TAB = 21'h00009;
	localparam logic [CODE_W-1:0] CH_NL  = 21'h0000A;
	localparam logic [CODE_W-1:0] CH_SP  = 21'h00020;

	typedef enum logic [2:0] {
		CL_DEF, CL_WS, CL_GRAPH, CL_QUOTE, CL_PUNCT, CL_OPEN, CL_CLOSE, CL_EOT
	} cls_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_LAY, ST_SR_RD, ST_SR_EV, ST_EM_RD, ST_EM_WR, ST_END, ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		LAY_PLACE, LAY_NL, LAY_HANG, LAY_SEARCH
	} lay_t;

	// One entry of the pending line ring
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [MET_W-1:0]  adv;
		logic [MET_W-1:0]  size;
		logic [MET_W-1:0]  asc;
		logic [MET_W-1:0]  desc;
		logic [IDX_W-1:0]  idx;
		logic [MET_W-1:0]  x;
	} entry_t;

	// One placed glyph as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0] glyph_index;
		logic [MET_W-1:0] x_position;
		logic [IDX_W-1:0] line_number;
		logic             line_done;
		logic [TOP_W-1:0] line_top;
		logic [MET_W-1:0] line_height;
		logic [MET_W-1:0] line_ascent;
		logic [MET_W-1:0] line_descent;
		logic             last_result;
	} result_t;

	// Break class of a code point; everything above ASCII is default
	function automatic cls_t char_class(input logic [CODE_W-1:0] c);
		cls_t cl;
		cl = CL_DEF;
		if (c == CH_NUL) begin
			cl = CL_EOT;
		end else if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
			cl = CL_WS;
		end else if (c[CODE_W-1:7] == '0) begin
			case (c[6:0])
				7'h3D, 7'h2B, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26,
				7'h2A, 7'h5C, 7'h7C, 7'h3C, 7'h3E, 7'h2F, 7'h7E: cl = CL_GRAPH;
				7'h27, 7'h22:                                     cl = CL_QUOTE;
				7'h2C, 7'h2E, 7'h3F, 7'h21, 7'h3B, 7'h3A, 7'h2D: cl = CL_PUNCT;
				7'h28, 7'h5B, 7'h7B:                              cl = CL_OPEN;
				7'h29, 7'h5D, 7'h7D:                              cl = CL_CLOSE;
				default:                                          cl = CL_DEF;
			endcase
		end
		return cl;
	endfunction

	// Legal break between glyph c and the glyph nc that follows it
	function automatic logic break_after(input logic [CODE_W-1:0] c,
			input logic [CODE_W-1:0] nc);
		cls_t cl;
		cls_t ncl;
		logic ok;
		cl  = char_class(c);
		ncl = char_class(nc);
		if (cl == CL_EOT || c == CH_NL) begin
			ok = 1'b1;
		end else if (cl == CL_DEF && ncl == CL_PUNCT) begin
			ok = 1'b0;
		end else if ((cl == CL_WS) != (ncl == CL_WS)) begin
			ok = 1'b1;
		end else if (cl == CL_WS && nc == CH_NL) begin
			ok = 1'b1;
		end else if (cl == CL_PUNCT && ncl != CL_PUNCT && ncl != CL_CLOSE
				&& ncl != CL_QUOTE) begin
			ok = 1'b1;
		end else begin
			ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

>>> sv/gtlb_if.sv
// Channel interfaces of the line breaker: glyph input, placed glyph output, register writes.
interface gtlb_glyph_if import gtlb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] char_code;
	logic [MET_W-1:0]  advance;
	logic [MET_W-1:0]  font_size;
	logic [MET_W-1:0]  ascent;
	logic [MET_W-1:0]  descent;
	logic              end_of_paragraph;
	modport source (output valid, char_code, advance, font_size, ascent, descent,
		end_of_paragraph, input ready);
	modport sink (input valid, char_code, advance, font_size, ascent, descent,
		end_of_paragraph, output ready);
endinterface

interface gtlb_place_if import gtlb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] glyph_index;
	logic [MET_W-1:0] x_position;
	logic [IDX_W-1:0] line_number;
	logic             line_done;
	logic [TOP_W-1:0] line_top;
	logic [MET_W-1:0] line_height;
	logic [MET_W-1:0] line_ascent;
	logic [MET_W-1:0] line_descent;
	logic             last_result;
	modport source (output valid, glyph_index, x_position, line_number, line_done,
		line_top, line_height, line_ascent, line_descent, last_result, input ready);
	modport sink (input valid, glyph_index, x_position, line_number, line_done,
		line_top, line_height, line_ascent, line_descent, last_result, output ready);
endinterface

interface gtlb_cfg_if import gtlb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MET_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/gtlb_ring.sv
// Pending line ring memory: one write port, one registered read port.
module gtlb_ring import gtlb_pkg::*; #(
	parameter int DEPTH = LINE_GLYPHS_DEF,
	parameter int AW    = $clog2(LINE_GLYPHS_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/greedy_text_line_breaker.sv
// Top level of the greedy line breaker: sequencer around the pending line ring.
//
// Use: glyphs arrive on the glyphs channel, one word per glyph, with their
// advance, font size, ascent, descent and an end-of-paragraph mark. Each
// finished line leaves on the placed channel, one word per glyph, in order;
// the last word of a line carries line_done and the line metrics, and the
// last word caused by an input glyph carries last_result. Registers are
// written on cfg (index 0 wrap width, 1 first line inset, 2 line inset,
// 3 line gap); the user must do so only while the block is idle, as the
// block does not enforce it; cfg is always ready. A glyph that only places
// goes through write, fetch, lay, fetch, end check and flush. A back search
// reads and evaluates each glyph walked back; each finished line reads and
// writes out each glyph emitted and re-lays each carried glyph, through the
// single ring read port. Results leave through an output register; the last
// result of a glyph is held back one word until the glyph is fully done.
// Reset clears the registers, empties the ring and parks the pen at the
// first line inset. When the receiver stalls, the emit loop waits and no
// new glyph is taken until the current glyph's words are all queued.
module greedy_text_line_breaker import gtlb_pkg::*; #(
	parameter int LINE_GLYPHS = LINE_GLYPHS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	gtlb_glyph_if.sink   glyphs,
	gtlb_place_if.source placed,
	gtlb_cfg_if.sink     cfg
);

	localparam int AW = $clog2(LINE_GLYPHS);
	localparam int CW = $clog2(LINE_GLYPHS + 1);
	localparam logic [CW:0] DEPTH_C = (CW+1)'(LINE_GLYPHS);

	// Position off entries past base, modulo the ring depth
	function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= DEPTH_C) begin
			s = s - DEPTH_C;
		end
		return s[AW-1:0];
	endfunction

	state_t           state_q, state_d;
	logic [MET_W-1:0] wrap_q, first_q, inset_q, gap_q;
	logic [MET_W-1:0] pen_q;
	logic [TOP_W-1:0] top_q;
	logic [IDX_W-1:0] line_q, gcnt_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    cnt_q, qn_q, e_q, k_q, m_q;
	logic             eop_q, nocheck_q, brk_q;
	logic [CODE_W-1:0] nc_q;
	logic [MET_W-1:0] acc_h_q, acc_a_q, acc_d_q;
	logic             hold_v_q, out_v_q;
	result_t          hold_q, out_q;

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	entry_t           mem_wdata, g;

	logic [AW-1:0]    lay_pos, em_pos, sr_pos;
	logic [MET_W:0]   pen_sum;
	logic [MET_W-1:0] pen_adv;
	logic             over, found, em_last, out_free, push_ok, out_load;
	lay_t             lay_kind;
	logic [MET_W-1:0] em_h, em_a, em_d;
	logic [TOP_W+1:0] top_sum;
	logic [TOP_W-1:0] top_next;
	result_t          em_res;

	gtlb_ring #(.DEPTH(LINE_GLYPHS), .AW(AW)) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (g)
	);

	// Ring positions of the next glyph to lay, the emit cursor and the search cursor
	assign lay_pos = ring_at(head_q, cnt_q);
	assign em_pos  = ring_at(head_q, k_q);
	assign sr_pos  = ring_at(head_q, e_q);

	// Pen advance and overflow test
	assign pen_sum = {1'b0, pen_q} + {1'b0, g.adv};
	assign pen_adv = pen_sum[MET_W] ? '1 : pen_sum[MET_W-1:0];
	assign over    = (wrap_q != '0) && (pen_sum > {1'b0, wrap_q});
	assign found   = break_after(g.code, nc_q);

	// Classify the glyph being laid
	always_comb begin
		priority if (nocheck_q) begin
			lay_kind = LAY_PLACE;
		end else if (g.code == CH_NL) begin
			lay_kind = LAY_NL;
		end else if (over && char_class(g.code) == CL_WS) begin
			lay_kind = LAY_HANG;
		end else if (over && cnt_q != '0 && cnt_q < CW'(LINE_GLYPHS)) begin
			lay_kind = LAY_SEARCH;
		end else begin
			lay_kind = LAY_PLACE;
		end
	end

	// Line metrics folded in as each glyph is emitted
	assign em_h    = (g.size > acc_h_q) ? g.size : acc_h_q;
	assign em_a    = (g.asc > acc_a_q) ? g.asc : acc_a_q;
	assign em_d    = (g.desc > acc_d_q) ? g.desc : acc_d_q;
	assign em_last = (k_q == m_q - 1'b1);
	assign top_sum = {2'b00, top_q} + (TOP_W+2)'(em_h) + (TOP_W+2)'(gap_q);
	assign top_next = (top_sum[TOP_W+1:TOP_W] != 2'b00) ? '1 : top_sum[TOP_W-1:0];

	always_comb begin
		em_res              = '0;
		em_res.glyph_index  = g.idx;
		em_res.x_position   = g.x;
		em_res.line_number  = line_q;
		em_res.line_done    = em_last;
		if (em_last) begin
			em_res.line_top     = top_q;
			em_res.line_height  = em_h;
			em_res.line_ascent  = em_a;
			em_res.line_descent = em_d;
		end
	end

	assign out_free = !out_v_q || placed.ready;
	assign push_ok  = !hold_v_q || out_free;

	// Output register loads from the held word this cycle
	assign out_load = (state_q == ST_EM_WR && push_ok && hold_v_q)
		|| (state_q == ST_FLUSH && hold_v_q && out_free);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (glyphs.valid) state_d = ST_FETCH;
			ST_FETCH: state_d = (qn_q == '0) ? ST_END : ST_LAY;
			ST_LAY: begin
				unique case (lay_kind)
					LAY_NL:     state_d = ST_EM_RD;
					LAY_SEARCH: state_d = (cnt_q == CW'(1)) ? ST_EM_RD : ST_SR_RD;
					default:    state_d = ST_FETCH;
				endcase
			end
			ST_SR_RD: state_d = ST_SR_EV;
			ST_SR_EV: state_d = (found || e_q == CW'(1)) ? ST_EM_RD : ST_SR_RD;
			ST_EM_RD: state_d = ST_EM_WR;
			ST_EM_WR: begin
				if (push_ok) begin
					state_d = em_last ? ST_FETCH : ST_EM_RD;
				end
			end
			ST_END: begin
				if (cnt_q == CW'(LINE_GLYPHS) || (eop_q && cnt_q != '0)) begin
					state_d = ST_EM_RD;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: if (!hold_v_q || out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lay_pos;
		mem_wdata = g;
		mem_re    = 1'b0;
		mem_raddr = lay_pos;
		unique case (state_q)
			ST_IDLE: begin
				mem_we         = glyphs.valid;
				mem_wdata.code = glyphs.char_code;
				mem_wdata.adv  = glyphs.advance;
				mem_wdata.size = glyphs.font_size;
				mem_wdata.asc  = glyphs.ascent;
				mem_wdata.desc = glyphs.descent;
				mem_wdata.idx  = gcnt_q;
				mem_wdata.x    = '0;
			end
			ST_FETCH: mem_re = (qn_q != '0);
			ST_LAY: begin
				mem_we      = 1'b1;
				mem_wdata.x = pen_q;
			end
			ST_SR_RD: begin
				mem_re    = 1'b1;
				mem_raddr = sr_pos;
			end
			ST_EM_RD: begin
				mem_re    = 1'b1;
				mem_raddr = em_pos;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign glyphs.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;

	assign placed.valid        = out_v_q;
	assign placed.glyph_index  = out_q.glyph_index;
	assign placed.x_position   = out_q.x_position;
	assign placed.line_number  = out_q.line_number;
	assign placed.line_done    = out_q.line_done;
	assign placed.line_top     = out_q.line_top;
	assign placed.line_height  = out_q.line_height;
	assign placed.line_ascent  = out_q.line_ascent;
	assign placed.line_descent = out_q.line_descent;
	assign placed.last_result  = out_q.last_result;

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wrap_q    <= '0;
			first_q   <= '0;
			inset_q   <= '0;
			gap_q     <= '0;
			pen_q     <= '0;
			top_q     <= '0;
			line_q    <= '0;
			gcnt_q    <= '0;
			head_q    <= '0;
			cnt_q     <= '0;
			qn_q      <= '0;
			e_q       <= '0;
			k_q       <= '0;
			m_q       <= '0;
			eop_q     <= 1'b0;
			nocheck_q <= 1'b0;
			brk_q     <= 1'b0;
			nc_q      <= '0;
			acc_h_q   <= '0;
			acc_a_q   <= '0;
			acc_d_q   <= '0;
			hold_v_q  <= 1'b0;
			hold_q    <= '0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			state_q <= state_d;

			// Register writes; a first line inset write before any glyph also moves the pen
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_WRAP_WIDTH: wrap_q <= cfg.data;
					REG_FIRST_INSET: begin
						first_q <= cfg.data;
						if (gcnt_q == '0 && cnt_q == '0 && line_q == '0) begin
							pen_q <= cfg.data;
						end
					end
					REG_LINE_INSET: inset_q <= cfg.data;
					REG_LINE_GAP:   gap_q <= cfg.data;
					default:        gap_q <= gap_q;
				endcase
			end

			// Drop the output word once taken, unless a new one moves in
			if (out_v_q && placed.ready && !out_load) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (glyphs.valid) begin
						gcnt_q <= gcnt_q + 1'b1;
						qn_q   <= CW'(1);
						eop_q  <= glyphs.end_of_paragraph;
					end
				end
				ST_LAY: begin
					cnt_q     <= cnt_q + 1'b1;
					qn_q      <= qn_q - 1'b1;
					nocheck_q <= 1'b0;
					unique case (lay_kind)
						LAY_PLACE: pen_q <= pen_adv;
						LAY_NL: begin
							m_q     <= cnt_q + 1'b1;
							k_q     <= '0;
							brk_q   <= 1'b0;
							acc_h_q <= '0;
							acc_a_q <= '0;
							acc_d_q <= '0;
						end
						LAY_SEARCH: begin
							e_q     <= cnt_q - 1'b1;
							nc_q    <= g.code;
							m_q     <= cnt_q;
							k_q     <= '0;
							brk_q   <= 1'b1;
							acc_h_q <= '0;
							acc_a_q <= '0;
							acc_d_q <= '0;
						end
						default: pen_q <= pen_q;
					endcase
				end
				ST_SR_EV: begin
					// Break after entry e, or before the overflowing glyph if none
					if (found) begin
						m_q <= e_q + 1'b1;
					end else begin
						nc_q <= g.code;
						e_q  <= e_q - 1'b1;
						m_q  <= cnt_q - 1'b1;
					end
				end
				ST_EM_WR: begin
					if (push_ok) begin
						// Held words never carry last_result; only the flush sets it
						if (hold_v_q) begin
							out_q   <= hold_q;
							out_v_q <= 1'b1;
						end
						hold_q   <= em_res;
						hold_v_q <= 1'b1;
						acc_h_q  <= em_h;
						acc_a_q  <= em_a;
						acc_d_q  <= em_d;
						k_q      <= k_q + 1'b1;
						if (em_last) begin
							// Retire the line; what stays behind is carried back to be re-laid
							head_q    <= ring_at(head_q, m_q);
							qn_q      <= qn_q + cnt_q - m_q;
							cnt_q     <= '0;
							nocheck_q <= brk_q;
							top_q     <= top_next;
							line_q    <= line_q + 1'b1;
							pen_q     <= inset_q;
						end
					end
				end
				ST_END: begin
					if (cnt_q == CW'(LINE_GLYPHS) || (eop_q && cnt_q != '0)) begin
						m_q     <= cnt_q;
						k_q     <= '0;
						brk_q   <= 1'b0;
						acc_h_q <= '0;
						acc_a_q <= '0;
						acc_d_q <= '0;
					end else if (eop_q) begin
						pen_q  <= first_q;
						top_q  <= '0;
						line_q <= '0;
						gcnt_q <= '0;
						eop_q  <= 1'b0;
					end
				end
				ST_FLUSH: begin
					if (hold_v_q && out_free) begin
						out_q    <= {hold_q[$bits(result_t)-1:1], 1'b1};
						out_v_q  <= 1'b1;
						hold_v_q <= 1'b0;
					end
				end
				default: begin
					hold_v_q <= hold_v_q;
				end
			endcase
		end
	end

	// Laid plus unlaid glyphs never outgrow the ring
	a_ring_occ: assert property (@(posedge clk) disable iff (!arst_n)
		((CW+1)'(cnt_q) + (CW+1)'(qn_q)) <= DEPTH_C)
		else $error("ring occupancy above depth");

	// Idle only with nothing held back and nothing left to lay
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!hold_v_q && qn_q == '0 && cnt_q < CW'(LINE_GLYPHS)))
		else $error("idle with work left");

	// A glyph's final word always closes a line
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(placed.valid && placed.last_result) |-> placed.line_done)
		else $error("last result not on a line end");

	// Emit cursor stays inside the line being emitted
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EM_WR) |-> (k_q < m_q))
		else $error("emit cursor past line end");

endmodule
